### hdl/assert_macros.svh
// Assertion macros used by the checker file of the allocator.
// No dependencies; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define QFBA_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, disabled while reset is high.
`define QFBA_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

### hdl/qfba_pkg.sv
// Types, codes and small helper functions of the quick-fit allocator.
// No dependencies; imported by every allocator module.
package qfba_pkg;

  // Fixed shape of the allocator.
  localparam int NUM_CLASSES = 5;
  localparam int CLS_W = 3;
  localparam int ALU_W = 33;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;
  localparam int HEAP_SIZE_W = 25;
  localparam logic [15:0] MAX_REQ_SIZE = 16'd512;
  localparam logic [HEAP_SIZE_W-1:0] HEAP_SIZE_RESET = 25'd65536;

  // Request kinds.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE = 1'b1;

  // Result status codes.
  localparam logic [2:0] STATUS_OK = 3'd0;
  localparam logic [2:0] STATUS_TOO_LARGE = 3'd1;
  localparam logic [2:0] STATUS_EXHAUSTED = 3'd2;
  localparam logic [2:0] STATUS_SLOTS_FULL = 3'd3;
  localparam logic [2:0] STATUS_UNKNOWN = 3'd4;

  // Configuration register indexes (taken from paddr[2]).
  localparam logic REG_HEAP_BASE = 1'b0;
  localparam logic REG_HEAP_SIZE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] request_size;
    logic [31:0] chunk_address;
  } request_t;

  typedef struct packed {
    logic [31:0] address;
    logic [2:0]  status;
  } result_t;

  typedef struct packed {
    logic [31:0]            heap_base;
    logic [HEAP_SIZE_W-1:0] heap_size;
  } cfg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_ALLOC,
    S_POP,
    S_BUMP,
    S_COMMIT,
    S_PUSH,
    S_DONE
  } state_t;

  // Smallest size class that holds the requested bytes.
  function automatic logic [CLS_W-1:0] size_class(input logic [15:0] size);
    logic [CLS_W-1:0] cls;
    if (size <= 16'd32) cls = 3'd0;
    else if (size <= 16'd64) cls = 3'd1;
    else if (size <= 16'd128) cls = 3'd2;
    else if (size <= 16'd256) cls = 3'd3;
    else cls = 3'd4;
    return cls;
  endfunction

  // Block size in bytes of a class.
  function automatic logic [9:0] class_bytes(input logic [CLS_W-1:0] cls);
    return 10'd32 << cls;
  endfunction

endpackage

### hdl/qfba_alu.sv
// Shared add-and-compare unit of the allocator sequencer.
// Depends on qfba_pkg for the operand width.
module qfba_alu (
  input  logic [qfba_pkg::ALU_W-1:0] a,
  input  logic [qfba_pkg::ALU_W-1:0] b,
  input  logic [qfba_pkg::ALU_W-1:0] cmp,
  output logic [qfba_pkg::ALU_W-1:0] sum,
  output logic                       eq,
  output logic                       gt
);
  import qfba_pkg::*;

  // One wide add, then an address-width equality and a full-width compare.
  always_comb begin
    sum = a + b;
    eq  = (sum[DATA_W-1:0] == cmp[DATA_W-1:0]);
    gt  = (sum > cmp);
  end

endmodule

### hdl/qfba_regs.sv
// Configuration register file of the allocator behind an APB-style port.
// Depends on qfba_pkg for the register codes and the cfg_t struct.
module qfba_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qfba_pkg::ADDR_W-1:0] paddr,
  input  logic [qfba_pkg::DATA_W-1:0] pwdata,
  output logic [qfba_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output qfba_pkg::cfg_t              cfg
);
  import qfba_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heap_base <= '0;
      cfg.heap_size <= HEAP_SIZE_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_HEAP_BASE: cfg.heap_base <= pwdata;
        REG_HEAP_SIZE: cfg.heap_size <= pwdata[HEAP_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data, zero-extended.
  always_comb begin
    unique case (reg_sel)
      REG_HEAP_BASE: prdata = cfg.heap_base;
      REG_HEAP_SIZE: prdata = DATA_W'(cfg.heap_size);
      default:       prdata = '0;
    endcase
  end

endmodule

### hdl/quick_fit_block_allocator_top.sv
// Top level of the quick-fit block allocator: sequencer, owned table and free stacks.
// Depends on qfba_pkg, qfba_alu and qfba_regs.
//
// A request is taken when start is high and busy is low; its result appears on
// result for one cycle with done high and cannot be held off. Allocates of up to
// 512 bytes and frees scan the owned table, one entry per cycle through the table's
// single read port, compared in one shared adder and comparator; the first scan
// cycle only primes the read. A free that matches a slot then passes a push state;
// an allocate granted a slot passes an allocate state, a pop from its free stack or
// a bump of the heap pointer, and a commit state, and ends early when the heap is
// exhausted or the block limit is reached. A scan that finds nothing, and an
// allocate above 512 bytes, which skips the scan, go straight to done; busy drops
// in the cycle after done. After reset the owned table is cleared in a pass over
// every slot, during which busy stays high; configuration writes are taken at any
// time.
module quick_fit_block_allocator_top #(
  parameter int MAX_BLOCKS  = 64,
  parameter int OFFSET_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  qfba_pkg::request_t          request,
  output logic                        done,
  output qfba_pkg::result_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qfba_pkg::ADDR_W-1:0] paddr,
  input  logic [qfba_pkg::DATA_W-1:0] pwdata,
  output logic [qfba_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import qfba_pkg::*;

  localparam int SLOT_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int TOP_W     = OFFSET_BITS + 1;
  localparam int OW        = 1 + CLS_W + OFFSET_BITS;
  localparam int STK_AW    = CLS_W + SLOT_W;
  localparam int STK_DEPTH = NUM_CLASSES * (2 ** SLOT_W);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_BLOCKS - 1);
  localparam logic [CNT_W-1:0]  BLOCK_MAX = CNT_W'(MAX_BLOCKS);
  localparam logic [ALU_W-1:0]  HEAP_CAP  = ALU_W'(1) << OFFSET_BITS;

  cfg_t cfg;

  state_t state, state_next;

  // Control registers.
  logic [SLOT_W-1:0] scan_idx;
  logic              rd_vld;
  logic [TOP_W-1:0]  heap_top;
  logic [CNT_W-1:0]  block_count;
  logic [CNT_W-1:0]  stack_depth [NUM_CLASSES];

  // Payload registers.
  request_t              req_q;
  logic [CLS_W-1:0]      cls_q;
  logic [SLOT_W-1:0]     slot_q;
  logic [SLOT_W-1:0]     rd_idx;
  logic [OFFSET_BITS-1:0] offset_q;
  result_t               result_q;

  // Memories.
  logic [OW-1:0]          owned_mem [MAX_BLOCKS];
  logic [OW-1:0]          owned_rdata;
  logic                   owned_we;
  logic [SLOT_W-1:0]      owned_waddr;
  logic [OW-1:0]          owned_wdata;
  logic [OFFSET_BITS-1:0] stack_mem [STK_DEPTH];
  logic [OFFSET_BITS-1:0] stack_rdata;
  logic                   stack_we;
  logic                   stack_re;
  logic [STK_AW-1:0]      stack_waddr;
  logic [STK_AW-1:0]      stack_raddr;

  // Shared unit operands and results.
  logic [ALU_W-1:0] alu_a, alu_b, alu_cmp, alu_sum;
  logic             alu_eq, alu_gt;
  logic [ALU_W-1:0] heap_limit;

  // Decoded scan and stack conditions.
  logic                   ent_valid;
  logic [CLS_W-1:0]       ent_cls;
  logic [OFFSET_BITS-1:0] ent_off;
  logic                   is_free;
  logic                   scan_hit;
  logic                   scan_last;
  logic [CNT_W-1:0]       depth_sel;
  logic [CNT_W-1:0]       depth_dec;
  logic                   push_ok;
  logic                   too_large;

  qfba_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  qfba_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .cmp (alu_cmp),
    .sum (alu_sum),
    .eq  (alu_eq),
    .gt  (alu_gt)
  );

  // Owned-table entry fields and scan outcome.
  assign ent_valid = owned_rdata[OW-1];
  assign ent_cls   = owned_rdata[OW-2 -: CLS_W];
  assign ent_off   = owned_rdata[OFFSET_BITS-1:0];
  assign is_free   = (req_q.kind == KIND_FREE);
  assign scan_hit  = rd_vld && (is_free ? (ent_valid && alu_eq) : !ent_valid);
  assign scan_last = rd_vld && (rd_idx == LAST_SLOT);
  assign too_large = (request.request_size > MAX_REQ_SIZE);

  // Free stack of the current class.
  assign depth_sel = stack_depth[cls_q];
  assign depth_dec = depth_sel - 1'b1;
  assign push_ok   = (cls_q < CLS_W'(NUM_CLASSES)) && (depth_sel < BLOCK_MAX);

  // The bump pointer may not pass the configured size nor the offset range.
  assign heap_limit = (ALU_W'(cfg.heap_size) > HEAP_CAP) ? HEAP_CAP : ALU_W'(cfg.heap_size);

  // Operand selection for the shared unit.
  always_comb begin
    unique case (state)
      S_SCAN: begin
        alu_a   = ALU_W'(cfg.heap_base);
        alu_b   = ALU_W'(ent_off);
        alu_cmp = ALU_W'(req_q.chunk_address);
      end
      S_BUMP: begin
        alu_a   = ALU_W'(heap_top);
        alu_b   = ALU_W'(class_bytes(cls_q));
        alu_cmp = heap_limit;
      end
      default: begin
        alu_a   = ALU_W'(cfg.heap_base);
        alu_b   = ALU_W'(offset_q);
        alu_cmp = '0;
      end
    endcase
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (scan_idx == LAST_SLOT) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          if (request.kind == KIND_ALLOC && too_large) state_next = S_DONE;
          else state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) state_next = is_free ? S_PUSH : S_ALLOC;
        else if (scan_last) state_next = S_DONE;
      end
      S_ALLOC: begin
        if (depth_sel != '0) state_next = S_POP;
        else if (block_count >= BLOCK_MAX) state_next = S_DONE;
        else state_next = S_BUMP;
      end
      S_POP:    state_next = S_COMMIT;
      S_BUMP:   state_next = alu_gt ? S_DONE : S_COMMIT;
      S_COMMIT: state_next = S_DONE;
      S_PUSH:   state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // State outputs: handshake and memory port controls.
  always_comb begin
    busy        = 1'b1;
    done        = 1'b0;
    owned_we    = 1'b0;
    owned_waddr = slot_q;
    owned_wdata = '0;
    stack_we    = 1'b0;
    stack_re    = 1'b0;
    stack_waddr = {cls_q, depth_sel[SLOT_W-1:0]};
    stack_raddr = {cls_q, depth_dec[SLOT_W-1:0]};
    unique case (state)
      S_CLEAR: begin
        owned_we    = 1'b1;
        owned_waddr = scan_idx;
      end
      S_IDLE:   busy = 1'b0;
      S_ALLOC:  stack_re = (depth_sel != '0);
      S_COMMIT: begin
        owned_we    = 1'b1;
        owned_wdata = {1'b1, cls_q, offset_q};
      end
      S_PUSH: begin
        owned_we = 1'b1;
        stack_we = push_ok;
      end
      S_DONE:   done = 1'b1;
      default: ;
    endcase
  end

  assign result = result_q;

  // Owned table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (owned_we) owned_mem[owned_waddr] <= owned_wdata;
    owned_rdata <= owned_mem[scan_idx];
  end

  // Free stacks of all classes in one memory, addressed by class and depth.
  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_waddr] <= offset_q;
    if (stack_re) stack_rdata <= stack_mem[stack_raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      scan_idx    <= '0;
      rd_vld      <= 1'b0;
      heap_top    <= '0;
      block_count <= '0;
      for (int i = 0; i < NUM_CLASSES; i++) stack_depth[i] <= '0;
    end else begin
      state  <= state_next;
      rd_vld <= (state == S_SCAN) && (state_next == S_SCAN);
      // The scan index saturates at the last slot and rests at zero when idle.
      if (state == S_IDLE) scan_idx <= '0;
      else if ((state == S_CLEAR || state == S_SCAN) && scan_idx != LAST_SLOT)
        scan_idx <= scan_idx + 1'b1;
      if (state == S_ALLOC && depth_sel != '0) stack_depth[cls_q] <= depth_dec;
      if (state == S_PUSH && push_ok) stack_depth[cls_q] <= depth_sel + 1'b1;
      if (state == S_BUMP && !alu_gt) begin
        heap_top    <= alu_sum[TOP_W-1:0];
        block_count <= block_count + 1'b1;
      end
    end
  end

  // Request payload, working values and the result register.
  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_q    <= request;
          cls_q    <= size_class(request.request_size);
          result_q <= '{address: '0, status: STATUS_TOO_LARGE};
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          slot_q <= rd_idx;
          if (is_free) begin
            cls_q    <= ent_cls;
            offset_q <= ent_off;
          end
        end else if (scan_last) begin
          result_q <= '{address: '0,
                        status: (is_free ? STATUS_UNKNOWN : STATUS_SLOTS_FULL)};
        end
      end
      S_ALLOC:  result_q <= '{address: '0, status: STATUS_SLOTS_FULL};
      S_POP:    offset_q <= stack_rdata;
      S_BUMP: begin
        if (alu_gt) result_q <= '{address: '0, status: STATUS_EXHAUSTED};
        else offset_q <= heap_top[OFFSET_BITS-1:0];
      end
      S_COMMIT: result_q <= '{address: alu_sum[DATA_W-1:0], status: STATUS_OK};
      S_PUSH:   result_q <= '{address: '0, status: STATUS_OK};
      default: ;
    endcase
  end

endmodule

### hdl/qfba_checker.sv
// Port-level checks of the allocator top level, bound to it below.
// Depends on qfba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qfba_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input qfba_pkg::result_t  result
);
  import qfba_pkg::*;

  // A taken request keeps the block busy until its result is shown.
  `QFBA_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // Results are shown only while a request is in flight.
  `QFBA_ASSERT_SAME(a_done_busy, clk, rst, done, busy)
  // One result per request: the done strobe is never repeated back to back.
  `QFBA_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  // Only a granted block carries an address.
  `QFBA_ASSERT_SAME(a_fail_zero, clk, rst, done && result.status != STATUS_OK, result.address == '0)
  // Status codes stay within the defined set.
  `QFBA_ASSERT_SAME(a_status_range, clk, rst, done, result.status <= STATUS_UNKNOWN)

endmodule

bind quick_fit_block_allocator_top qfba_checker u_qfba_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for quick_fit_block_allocator_top: allocate and free requests
// checked against a cycle-free model of the allocator. Depends on qfba_pkg and the RTL.
module tb;
  import qfba_pkg::*;

  localparam int BLOCK_LIMIT = 64;
  localparam int OFF_W = 24;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_REQUESTS = 196;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  request_t            request;
  logic                done;
  result_t             result;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Allocator image: configuration, bump pointer, free stacks and owned table.
  logic [31:0]          cfg_base;
  logic [24:0]          cfg_size;
  logic [24:0]          bump_top;
  int unsigned          blocks_cut;
  logic [OFF_W-1:0]     stack_mem [NUM_CLASSES][BLOCK_LIMIT];
  int unsigned          stack_depth [NUM_CLASSES];
  logic [OFF_W-1:0]     own_off [BLOCK_LIMIT];
  logic [2:0]           own_cls [BLOCK_LIMIT];
  logic                 own_valid [BLOCK_LIMIT];

  result_t answers_due [$];
  result_t last_answer;
  result_t want;
  int      failures;
  int      requests_sent;
  int      answers_seen;
  int      status_tally [5];
  bit      steady;

  quick_fit_block_allocator_top #(
    .MAX_BLOCKS(BLOCK_LIMIT),
    .OFFSET_BITS(OFF_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Computes the answer to one request and updates the allocator image.
  function automatic result_t allocator_answer(input request_t req);
    result_t     ans;
    logic [2:0]  cls;
    logic [9:0]  bytes;
    logic [25:0] reach;
    logic [OFF_W-1:0] off;
    int          slot;
    ans.address = '0;
    slot = -1;
    if (req.kind == KIND_FREE) begin
      ans.status = STATUS_UNKNOWN;
      for (int i = 0; i < BLOCK_LIMIT; i++)
        if (slot < 0 && own_valid[i] && cfg_base + 32'(own_off[i]) == req.chunk_address)
          slot = i;
      if (slot >= 0) begin
        own_valid[slot] = 1'b0;
        cls = own_cls[slot];
        if (stack_depth[cls] < BLOCK_LIMIT) begin
          stack_mem[cls][stack_depth[cls]] = own_off[slot];
          stack_depth[cls]++;
        end
        ans.status = STATUS_OK;
      end
      return ans;
    end
    if (req.request_size > MAX_REQ_SIZE) begin
      ans.status = STATUS_TOO_LARGE;
      return ans;
    end
    cls = '0;
    while (req.request_size > (16'd32 << cls)) cls++;
    bytes = 10'd32 << cls;
    for (int i = 0; i < BLOCK_LIMIT; i++)
      if (slot < 0 && !own_valid[i]) slot = i;
    if (slot < 0) begin
      ans.status = STATUS_SLOTS_FULL;
      return ans;
    end
    if (stack_depth[cls] > 0) begin
      stack_depth[cls]--;
      off = stack_mem[cls][stack_depth[cls]];
    end else begin
      reach = 26'(bump_top) + 26'(bytes);
      if (blocks_cut >= BLOCK_LIMIT) begin
        ans.status = STATUS_SLOTS_FULL;
        return ans;
      end
      if (reach > 26'(cfg_size) || reach > (26'd1 << OFF_W)) begin
        ans.status = STATUS_EXHAUSTED;
        return ans;
      end
      off = bump_top[OFF_W-1:0];
      bump_top = reach[24:0];
      blocks_cut++;
    end
    own_valid[slot] = 1'b1;
    own_off[slot] = off;
    own_cls[slot] = cls;
    ans.address = cfg_base + 32'(off);
    ans.status = STATUS_OK;
    return ans;
  endfunction

  // Address of a randomly chosen block that is currently handed out.
  function automatic logic [31:0] some_owned_address(output bit found);
    int slots [$];
    for (int i = 0; i < BLOCK_LIMIT; i++)
      if (own_valid[i]) slots.push_back(i);
    found = (slots.size() != 0);
    if (!found) return $urandom;
    return cfg_base + 32'(own_off[slots[$urandom_range(slots.size() - 1)]]);
  endfunction

  function automatic request_t alloc_request(input logic [15:0] bytes_wanted);
    request_t req;
    req.kind = KIND_ALLOC;
    req.request_size = bytes_wanted;
    req.chunk_address = $urandom;
    return req;
  endfunction

  function automatic request_t free_request(input logic [31:0] addr);
    request_t req;
    req.kind = KIND_FREE;
    req.request_size = 16'($urandom);
    req.chunk_address = addr;
    return req;
  endfunction

  // A size that falls in a random class, now and then right on a class boundary.
  function automatic logic [15:0] class_size();
    int c;
    c = $urandom_range(NUM_CLASSES - 1);
    if ($urandom_range(9) == 0) return 16'(32 << c);
    return 16'($urandom_range(c == 0 ? 0 : (16 << c) + 1, 32 << c));
  endfunction

  // Sends one request; start drops at random cycles, busy or not, unless steady is set.
  task automatic issue_request(input request_t req);
    bit presented;
    forever begin
      presented = steady || ($urandom_range(99) >= 34);
      start <= presented;
      if (presented) request <= req;
      @(posedge clk);
      if (presented && !busy) break;
    end
    last_answer = allocator_answer(req);
    answers_due.push_back(last_answer);
    requests_sent++;
  endtask

  task automatic apb_access(input logic wr, input logic idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Writes a register once the allocator has gone quiet, then reads it back.
  task automatic set_register(input logic idx, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] stored;
    start <= 1'b0;
    while (answers_due.size() != 0 || busy) @(posedge clk);
    stored = (idx == REG_HEAP_SIZE) ? {7'd0, value[24:0]} : value;
    apb_access(1'b1, idx, value, readback);
    apb_access(1'b0, idx, 32'd0, readback);
    if (readback !== stored) begin
      $display("%0t: register %0d readback, expected %h, got %h", $time, idx, stored, readback);
      failures++;
    end
    if (idx == REG_HEAP_BASE) cfg_base = value;
    else cfg_size = value[24:0];
  endtask

  // Every class boundary, a zero size and sizes past the largest class.
  task automatic test_size_classes();
    logic [15:0] sizes [12];
    sizes = '{16'd0, 16'd32, 16'd33, 16'd64, 16'd65, 16'd128, 16'd129, 16'd256,
              16'd257, 16'd512, 16'd513, 16'hFFFF};
    foreach (sizes[i]) issue_request(alloc_request(sizes[i]));
  endtask

  // Freed blocks come back last in, first out; double and stray frees are refused.
  task automatic test_free_and_reuse();
    logic [31:0] first_addr;
    logic [31:0] second_addr;
    issue_request(alloc_request(16'd1));
    first_addr = last_answer.address;
    issue_request(alloc_request(16'd20));
    second_addr = last_answer.address;
    issue_request(free_request(first_addr));
    issue_request(free_request(second_addr));
    issue_request(alloc_request(16'd32));
    issue_request(free_request(last_answer.address));
    issue_request(free_request(last_answer.address == 0 ? second_addr : second_addr));
    issue_request(free_request(32'hFFFF_FFFF));
  endtask

  // Bump growth stops exactly at heap_size, including a heap of zero bytes.
  task automatic test_heap_limits();
    set_register(REG_HEAP_SIZE, 32'(bump_top) + 32'd64);
    issue_request(alloc_request(16'd300));
    issue_request(alloc_request(16'd64));
    set_register(REG_HEAP_SIZE, 32'd0);
    issue_request(alloc_request(16'd257));
    set_register(REG_HEAP_SIZE, 32'd16777216);
  endtask

  // Addresses wrap past 2^32 and frees match against the current base only.
  task automatic test_base_shift();
    logic [31:0] granted;
    set_register(REG_HEAP_BASE, 32'hFFFF_FFE0);
    issue_request(alloc_request(16'd512));
    granted = last_answer.address;
    issue_request(free_request(granted - 32'hFFFF_FFE0));
    issue_request(free_request(granted));
  endtask

  // One configuration phase of mostly well-formed allocate and free traffic.
  task automatic test_random_mix(input int phase, input int count);
    logic [31:0] base_value;
    logic [31:0] size_value;
    logic [31:0] addr;
    logic [31:0] last_freed;
    bit          found;
    int          pick;
    case (phase)
      0: base_value = 32'd0;
      1: base_value = 32'hFFFF_FFFF;
      default: base_value = $urandom;
    endcase
    case (phase % 4)
      0: size_value = 32'd16777216;
      1: size_value = 32'h01FF_FFFF;
      2: size_value = 32'(bump_top) + $urandom_range(0, 600);
      default: size_value = $urandom_range(0, 70000);
    endcase
    set_register(REG_HEAP_BASE, base_value);
    set_register(REG_HEAP_SIZE, size_value);
    steady = (phase == 3);
    last_freed = $urandom;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      addr = some_owned_address(found);
      if (pick < 45 || (pick < 85 && !found)) begin
        issue_request(alloc_request(class_size()));
      end else if (pick < 85) begin
        issue_request(free_request(addr));
        last_freed = addr;
      end else begin
        case ($urandom_range(2))
          0: issue_request(free_request($urandom));
          1: issue_request(free_request(last_freed));
          default: issue_request(alloc_request(16'($urandom_range(513, 65535))));
        endcase
      end
    end
    steady = 1'b0;
  endtask

  // Every strobed result is compared with the oldest outstanding answer.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (answers_due.size() == 0) begin
        $display("%0t: result with nothing outstanding, got address %h status %0d",
                 $time, result.address, result.status);
        failures++;
      end else begin
        want = answers_due.pop_front();
        answers_seen++;
        if (want.status <= STATUS_UNKNOWN) status_tally[want.status]++;
        if (result.address !== want.address) begin
          $display("%0t: address mismatch, expected %h, got %h",
                   $time, want.address, result.address);
          failures++;
        end
        if (result.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, result.status);
          failures++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb timed out");
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    request <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_base = '0;
    cfg_size = HEAP_SIZE_RESET;
    bump_top = '0;
    blocks_cut = 0;
    failures = 0;
    requests_sent = 0;
    answers_seen = 0;
    steady = 1'b0;
    foreach (stack_depth[i]) stack_depth[i] = 0;
    foreach (own_valid[i]) own_valid[i] = 1'b0;
    foreach (status_tally[i]) status_tally[i] = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_size_classes();
    test_free_and_reuse();
    test_heap_limits();
    test_base_shift();
    for (int p = 0; p < RANDOM_PHASES; p++) test_random_mix(p, PHASE_REQUESTS);

    // Drain the last answers and leave room for any stray result.
    start <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("Sent %0d requests over %0d configuration phases, %0d blocks cut.",
             requests_sent, RANDOM_PHASES + 1, blocks_cut);
    $display("Answers ok %0d, too large %0d, exhausted %0d, slots full %0d, unknown %0d.",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
